// ----- rtl/core/d2f_pkg.sv -----
package d2f_pkg;

  localparam int unsigned MantBits  = 52;
  localparam int unsigned ExpBits   = 11;
  localparam int unsigned ScaleBias = 1043;
  localparam int unsigned SatShift  = 11;

  localparam logic [ExpBits-1:0] ExpAllOnes = '1;
  localparam logic [62:0]        MagMax     = '1;

  typedef struct packed {
    logic [63:0] fixed_word;
    logic        saturated;
  } d2f_result_t;

endpackage

// ----- rtl/core/d2f_convert.sv -----
module d2f_convert (
  input  logic [63:0]          double_bits_i,
  output d2f_pkg::d2f_result_t result_o
);
  import d2f_pkg::*;

  logic                sign;
  logic [ExpBits-1:0]  ex;
  logic [MantBits-1:0] frac;
  logic [MantBits:0]   mant;
  logic [11:0]         sh_pos;
  logic [11:0]         sh_neg;
  logic [62:0]         mag;
  logic [MantBits:0]   shr;
  logic [MantBits:0]   shr_m1;
  logic                is_nan;
  logic                is_inf;
  logic                is_zero_exp;

  assign sign        = double_bits_i[63];
  assign ex          = double_bits_i[62:52];
  assign frac        = double_bits_i[51:0];
  assign is_zero_exp = (ex == '0);
  assign is_nan      = (ex == ExpAllOnes) && (frac != '0);
  assign is_inf      = (ex == ExpAllOnes) && (frac == '0);
  assign mant        = {~is_zero_exp, frac};

  always_comb begin
    logic [11:0] eff;
    eff    = is_zero_exp ? 12'd1 : {1'b0, ex};
    // Left shift amount when eff >= bias, right shift amount otherwise.
    sh_pos = eff - 12'(ScaleBias);
    sh_neg = 12'(ScaleBias) - eff;
    shr    = mant >> sh_neg[5:0];
    shr_m1 = mant >> (sh_neg[5:0] - 6'd1);
    mag    = '0;
    result_o = '0;
    if (is_nan) begin
      result_o = '0;
    end else if (is_inf || (eff >= 12'(ScaleBias + SatShift))) begin
      result_o.fixed_word = {sign, MagMax};
      result_o.saturated  = 1'b1;
    end else begin
      if (eff >= 12'(ScaleBias)) begin
        mag = 63'(mant) << sh_pos[3:0];
      end else if (sh_neg > 12'(MantBits + 1)) begin
        mag = '0;
      end else begin
        mag = 63'(shr) + 63'(shr_m1[0]);
      end
      result_o.fixed_word = {sign, mag};
    end
  end

endmodule

// ----- rtl/core/double_to_s31_32_sign_magnitude_core.sv -----
// Converts an IEEE-754 binary64 bit pattern into a sign-magnitude S31.32 word.
// Input channel: double_bits_i with in_valid_i; the block drives in_stall_o.
// Output channel: fixed_word_o and saturated_o with out_valid_o; the receiver
// drives out_stall_i. A transfer happens on a rising edge with valid high and
// stall low.
// A word taken at one edge appears at the outputs after that edge. Throughput
// is one word per cycle while out_stall_i is low, set by the single conversion
// stage between the input port and the result register.
// When the receiver stalls, the result register holds its value and the
// input side stalls too, so nothing is lost; as soon as the held result is
// transferred a new word can be taken in the same cycle.
// NaN gives zero, infinity and values of magnitude 2^31 or more clamp to a
// magnitude field of 2^63-1 with saturated_o high, and ties round away from zero.
// Reset clears the output valid flag; the result register itself is not reset.
module double_to_s31_32_sign_magnitude_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] double_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] fixed_word_o,
  output logic        saturated_o
);
  import d2f_pkg::*;

  d2f_result_t conv;
  d2f_result_t res_q;
  logic        valid_q;
  logic        load;

  d2f_convert u_convert (
    .double_bits_i (double_bits_i),
    .result_o      (conv)
  );

  // The result register may load whenever it is empty or being drained.
  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= conv;
    end
  end

  assign out_valid_o  = valid_q;
  assign fixed_word_o = res_q.fixed_word;
  assign saturated_o  = res_q.saturated;

`ifndef NO_ASSERTIONS
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("accepted word did not produce a result");
  a_sat_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> fixed_word_o[62:0] == MagMax)
    else $error("saturated result without clamped magnitude");
  a_stall_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(fixed_word_o) && out_valid_o)
    else $error("stalled result changed");
`endif

endmodule

// ----- sim/d2f_checker.sv -----
module d2f_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] double_bits_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] fixed_word_i,
  input  logic        saturated_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import d2f_pkg::*;

  d2f_result_t expected_words_q[$];

  assign pending_o = expected_words_q.size();

  // Exact conversion: value * 2^32 = mant * 2^(exp - bias), one rounding step.
  function automatic d2f_result_t convert_double(logic [63:0] bits);
    d2f_result_t res;
    logic [ExpBits-1:0] ex;
    logic [MantBits-1:0] frac;
    logic [63:0] mant;
    logic [63:0] mag;
    int sh;
    int r;
    ex = bits[62:52];
    frac = bits[51:0];
    res.saturated = 1'b0;
    if (ex == ExpAllOnes && frac != '0) begin
      res.fixed_word = '0;
      return res;
    end
    if (ex == ExpAllOnes) begin
      res.saturated = 1'b1;
      res.fixed_word = {bits[63], MagMax};
      return res;
    end
    if (ex == '0) begin
      mant = {12'd0, frac};
      sh = 1 - int'(ScaleBias);
    end else begin
      mant = {11'd0, 1'b1, frac};
      sh = int'(ex) - int'(ScaleBias);
    end
    if (sh >= int'(SatShift)) begin
      res.saturated = 1'b1;
      mag = {1'b0, MagMax};
    end else if (sh >= 0) begin
      mag = mant << sh;
    end else begin
      r = -sh;
      if (r > int'(MantBits) + 1) mag = '0;
      else mag = (mant >> r) + ((mant >> (r - 1)) & 64'd1);
    end
    res.fixed_word = {bits[63], 63'd0} | mag;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    d2f_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_words_q.push_back(convert_double(double_bits_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_words_q.size() == 0) begin
          report_mismatch("unexpected transfer", fixed_word_i, '0);
        end else begin
          want = expected_words_q.pop_front();
          if (fixed_word_i !== want.fixed_word)
            report_mismatch("fixed_word", fixed_word_i, want.fixed_word);
          if (saturated_i !== want.saturated)
            report_mismatch("saturated", {63'd0, saturated_i}, {63'd0, want.saturated});
        end
      end
    end
  end
endmodule

// ----- sim/double_to_s31_32_sign_magnitude_core_tb.sv -----
module double_to_s31_32_sign_magnitude_core_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] double_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] fixed_word_o;
  logic        saturated_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  // Idle percentages for the sender and the receiver, set per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  localparam int unsigned CycleLimit = 200000;

  always #5 clk_i = ~clk_i;

  double_to_s31_32_sign_magnitude_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .double_bits_i,
    .out_valid_o, .out_stall_i, .fixed_word_o, .saturated_o
  );

  d2f_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .double_bits_i,
    .out_valid_i(out_valid_o), .out_stall_i, .fixed_word_i(fixed_word_o),
    .saturated_i(saturated_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // The watchdog ends a hung run with the failure verdict.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("double_to_s31_32_sign_magnitude_core regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random, or holds off entirely while hold_off is set.
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Random doubles lean on exponents near the interesting region: the
  // saturation boundary, the rounding region and the unit range.
  function automatic logic [63:0] pick_double();
    logic [63:0] v;
    int unsigned sel;
    v = {$urandom, $urandom};
    sel = $urandom_range(9);
    if (sel < 6) v[62:52] = 11'(1043 - 60 + $urandom_range(75));
    else if (sel == 6) v[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
    else if (sel == 7) v[51:0] = $urandom_range(1) ? '0 : {52{1'b1}};
    return v;
  endfunction

  // One transfer: present the word at a falling edge and hold it until taken.
  // Valid stays high afterwards so that words can follow back to back.
  task automatic send_word(logic [63:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    double_bits_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] directed[$];
    logic [63:0] e;
    directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                 64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000,
                 64'hFFF0_0000_0000_0001, 64'h0000_0000_0000_0001,
                 64'h800F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
                 64'hBFF0_0000_0000_0000, 64'h3DE0_0000_0000_0000,
                 64'hBDE0_0000_0000_0000, 64'h3DD0_0000_0000_0000,
                 64'h3DE8_0000_0000_0000, 64'h3DF8_0000_0000_0000,
                 64'h41DF_FFFF_FFFF_FFFF, 64'h41E0_0000_0000_0000,
                 64'hC1E0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h4330_0000_0000_0001,
                 64'h3FF0_0000_0000_0001};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_word(directed[i]);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 66) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 66) : 0;
      for (int k = 0; k < 350; k++) begin
        // Hold the receiver off for a long stretch so the input stalls too.
        if (ph == 0 && k == 100) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (60) @(negedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        // Pause the sender until every result has come back.
        if (k == 200) drain();
        e = pick_double();
        send_word(e);
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("double_to_s31_32_sign_magnitude_core regression: pass");
    end else begin
      $display("double_to_s31_32_sign_magnitude_core regression: fail");
    end
    $finish;
  end
endmodule

// ----- double_to_s31_32_sign_magnitude_core.f -----
rtl/core/d2f_pkg.sv
rtl/core/d2f_convert.sv
rtl/core/double_to_s31_32_sign_magnitude_core.sv
sim/d2f_checker.sv
sim/double_to_s31_32_sign_magnitude_core_tb.sv
